// ===== hdl/rrct_pkg.sv =====
// ----------------------------------------------------------------------------
// rrct_pkg
// shared constants and payload types for the round-robin completion times unit
// ----------------------------------------------------------------------------
package rrct_pkg;

  localparam int MAX_PROCS   = 16;
  localparam int TIME_BITS   = 20;
  localparam int ID_W        = 16;
  localparam int BURST_W     = 16;
  localparam int QUANTUM_W   = 16;
  localparam int IDX_W       = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W       = $clog2(MAX_PROCS + 1);
  localparam int SUM_W       = ((TIME_BITS > BURST_W) ? TIME_BITS : BURST_W) + 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = QUANTUM_W'(2);
  localparam logic [TIME_BITS-1:0] TIME_MAX      = {TIME_BITS{1'b1}};

  typedef struct packed {
    logic [ID_W-1:0]    proc_id;
    logic [BURST_W-1:0] burst;
    logic               last_proc;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]      out_id;
    logic [BURST_W-1:0]   out_burst;
    logic [TIME_BITS-1:0] turnaround;
    logic [TIME_BITS-1:0] waiting;
    logic                 last_result;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]    proc_id;
    logic [BURST_W-1:0] burst;
    logic               set_end;
  } queue_item_t;

endpackage

// ===== hdl/rrct_front.sv =====
// ----------------------------------------------------------------------------
// rrct_front
// accepts process requests and marks the request that closes a set
// ----------------------------------------------------------------------------
module rrct_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  rrct_pkg::in_item_t     in_data,
  output logic                   push,
  output rrct_pkg::queue_item_t  push_data,
  input  logic                   queue_full
);

  logic [rrct_pkg::IDX_W-1:0] cnt_r;
  logic [rrct_pkg::IDX_W-1:0] cnt_nxt;
  logic                       set_end;

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;
  assign set_end  = in_data.last_proc ||
                    (cnt_r == rrct_pkg::IDX_W'(rrct_pkg::MAX_PROCS - 1));

  assign push_data.proc_id = in_data.proc_id;
  assign push_data.burst   = in_data.burst;
  assign push_data.set_end = set_end;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push) begin
      cnt_nxt = set_end ? '0 : cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/rrct_queue.sv =====
// ----------------------------------------------------------------------------
// rrct_queue
// short request queue between the front and the scheduler
// ----------------------------------------------------------------------------
module rrct_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  rrct_pkg::queue_item_t  push_data,
  output logic                   full,
  input  logic                   pop,
  output logic                   not_empty,
  output rrct_pkg::queue_item_t  pop_data
);

  rrct_pkg::queue_item_t mem [rrct_pkg::QUEUE_DEPTH];

  logic [rrct_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [rrct_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [rrct_pkg::QPTR_W:0]   count_r, count_nxt;
  logic                        do_pop;

  assign full      = (count_r == (rrct_pkg::QPTR_W+1)'(rrct_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hdl/rrct_back.sv =====
// ----------------------------------------------------------------------------
// rrct_back
// process store, round-robin time slicing and result delivery
// ----------------------------------------------------------------------------
module rrct_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [rrct_pkg::QUANTUM_W-1:0]      cfg_data,
  input  logic                                q_not_empty,
  input  rrct_pkg::queue_item_t               q_data,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rrct_pkg::out_item_t                 out_data
);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [rrct_pkg::ID_W-1:0]      id_mem     [rrct_pkg::MAX_PROCS];
  logic [rrct_pkg::BURST_W-1:0]   burst_mem  [rrct_pkg::MAX_PROCS];
  logic [rrct_pkg::BURST_W-1:0]   rem_mem    [rrct_pkg::MAX_PROCS];
  logic [rrct_pkg::TIME_BITS-1:0] finish_mem [rrct_pkg::MAX_PROCS];

  logic [1:0]                       state_r, state_nxt;
  logic [rrct_pkg::QUANTUM_W-1:0]   quantum_r;
  logic [rrct_pkg::CNT_W-1:0]       loaded_r, loaded_nxt;
  logic [rrct_pkg::CNT_W-1:0]       finished_r, finished_nxt;
  logic [rrct_pkg::IDX_W-1:0]       visit_r, visit_nxt;
  logic [rrct_pkg::TIME_BITS-1:0]   elapsed_r, elapsed_nxt;
  logic                             out_valid_r, out_valid_nxt;
  rrct_pkg::out_item_t              out_r;

  logic [rrct_pkg::IDX_W-1:0]       load_idx;
  logic [rrct_pkg::IDX_W-1:0]       rd_idx;
  logic [rrct_pkg::ID_W-1:0]        rd_id;
  logic [rrct_pkg::BURST_W-1:0]     rd_burst;
  logic [rrct_pkg::BURST_W-1:0]     rd_rem;
  logic [rrct_pkg::TIME_BITS-1:0]   rd_finish;
  logic [rrct_pkg::QUANTUM_W-1:0]   q_eff;
  logic [rrct_pkg::BURST_W-1:0]     slice;
  logic [rrct_pkg::BURST_W-1:0]     rem_new;
  logic [rrct_pkg::SUM_W-1:0]       sum;
  logic [rrct_pkg::TIME_BITS-1:0]   elapsed_sat;
  logic [rrct_pkg::CNT_W-1:0]       visit_inc;
  logic [rrct_pkg::TIME_BITS-1:0]   burst_ext;
  logic                             all_done;
  logic                             run_step;
  logic                             out_load;
  logic                             emit_last;
  rrct_pkg::out_item_t              emit_item;

  assign load_idx  = loaded_r[rrct_pkg::IDX_W-1:0];
  assign rd_idx    = visit_r;
  assign rd_id     = id_mem[rd_idx];
  assign rd_burst  = burst_mem[rd_idx];
  assign rd_rem    = rem_mem[rd_idx];
  assign rd_finish = finish_mem[rd_idx];

  assign q_pop     = (state_r == ST_LOAD);
  assign all_done  = (finished_r == loaded_r);
  assign run_step  = (state_r == ST_RUN) && !all_done;
  assign out_load  = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign visit_inc = rrct_pkg::CNT_W'(visit_r) + rrct_pkg::CNT_W'(1);
  assign emit_last = (visit_inc == loaded_r);

  // one time slice for the visited process
  assign q_eff       = (quantum_r == '0) ? rrct_pkg::QUANTUM_W'(1) : quantum_r;
  assign slice       = (rd_rem >= q_eff) ? q_eff : rd_rem;
  assign rem_new     = rd_rem - slice;
  assign sum         = rrct_pkg::SUM_W'(elapsed_r) + rrct_pkg::SUM_W'(slice);
  assign elapsed_sat = (sum > rrct_pkg::SUM_W'(rrct_pkg::TIME_MAX)) ?
                       rrct_pkg::TIME_MAX : sum[rrct_pkg::TIME_BITS-1:0];

  assign burst_ext = rrct_pkg::TIME_BITS'(rd_burst);

  always_comb begin
    emit_item.out_id      = rd_id;
    emit_item.out_burst   = rd_burst;
    emit_item.turnaround  = rd_finish;
    emit_item.waiting     = (rd_finish >= burst_ext) ? rd_finish - burst_ext : '0;
    emit_item.last_result = emit_last;
  end

  always_comb begin
    state_nxt     = state_r;
    loaded_nxt    = loaded_r;
    finished_nxt  = finished_r;
    visit_nxt     = visit_r;
    elapsed_nxt   = elapsed_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_LOAD: begin
        if (q_not_empty) begin
          loaded_nxt = loaded_r + 1'b1;
          if (q_data.burst == '0) begin
            finished_nxt = finished_r + 1'b1;
          end
          if (q_data.set_end) begin
            state_nxt   = ST_RUN;
            visit_nxt   = '0;
            elapsed_nxt = '0;
          end
        end
      end
      ST_RUN: begin
        if (all_done) begin
          state_nxt = ST_EMIT;
          visit_nxt = '0;
        end else begin
          if (rd_rem != '0) begin
            elapsed_nxt = elapsed_sat;
            if (rem_new == '0) begin
              finished_nxt = finished_r + 1'b1;
            end
          end
          visit_nxt = (visit_inc >= loaded_r) ? '0 : visit_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          if (emit_last) begin
            state_nxt    = ST_LOAD;
            loaded_nxt   = '0;
            finished_nxt = '0;
            visit_nxt    = '0;
            elapsed_nxt  = '0;
          end else begin
            visit_nxt = visit_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_LOAD) && q_not_empty) begin
      id_mem[load_idx]    <= q_data.proc_id;
      burst_mem[load_idx] <= q_data.burst;
      rem_mem[load_idx]   <= q_data.burst;
      if (q_data.burst == '0) begin
        finish_mem[load_idx] <= '0;
      end
    end else if (run_step && (rd_rem != '0)) begin
      rem_mem[visit_r] <= rem_new;
      if (rem_new == '0) begin
        finish_mem[visit_r] <= elapsed_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= emit_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      quantum_r   <= rrct_pkg::QUANTUM_RESET;
      loaded_r    <= '0;
      finished_r  <= '0;
      visit_r     <= '0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      finished_r  <= finished_nxt;
      visit_r     <= visit_nxt;
      elapsed_r   <= elapsed_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        quantum_r <= cfg_data;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/round_robin_completion_times_unit.sv =====
// ----------------------------------------------------------------------------
// round_robin_completion_times_unit
// loads a set of processes, runs round-robin time slicing and reports
// turnaround and waiting time for each process in load order
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------
//  in      | in_valid / in_stall  | in_data   (proc_id, burst, last_proc)
//  out     | out_valid / out_stall| out_data  (id, burst, turnaround,
//          |                      |            waiting, last_result)
//  cfg     | cfg_valid / cfg_ready| cfg_data  (quantum)
//
// loading takes one request per cycle through a two-entry queue unless in_stall
// is high; scheduling walks the round-robin order, finished processes included;
// results then leave one per cycle while out_stall is low
// rst_n is synchronous and clears all control state; quantum returns to 2
// out_stall holds the result register; the queue takes up to two more
// requests, then in_stall rises
// ----------------------------------------------------------------------------
module round_robin_completion_times_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  rrct_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output rrct_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rrct_pkg::QUANTUM_W-1:0]   cfg_data
);

  logic                  push;
  rrct_pkg::queue_item_t push_data;
  logic                  queue_full;
  logic                  pop;
  logic                  not_empty;
  rrct_pkg::queue_item_t pop_data;

  assign cfg_ready = 1'b1;

  rrct_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push       (push),
    .push_data  (push_data),
    .queue_full (queue_full)
  );

  rrct_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_data  (pop_data)
  );

  rrct_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .q_not_empty (not_empty),
    .q_data      (pop_data),
    .q_pop       (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
